// ===== hdl/cdgss_pkg.sv =====
package cdgss_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_HSCROLL = 2'd1,
        MODE_VSCROLL = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    // Scroll directions; any other code leaves the screen alone.
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_BACK  = 2'd2;
    localparam logic [1:0] DIR_SPARE = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INDEX,
        OP_WRITE_PIX,
        OP_READ_PIX,
        OP_MOVE,
        OP_RESULT
    } op_t;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_BAND,
        SRC_FILL,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t src;
        logic dst_band;
    } cmd_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] dir;
        logic       wrap;
        logic       err;
    } stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PIXEL,
        ST_BAND,
        ST_SHIFT,
        ST_REFILL,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/cdgss_req_if.sv =====
interface cdgss_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] tile_col;
    logic [4:0] tile_row;
    logic [2:0] pix_col;
    logic [3:0] pix_row;
    logic [7:0] pen_color;
    logic [1:0] direction;
    logic       wrap;
    logic [7:0] fill_color;

    modport source (
        output valid, mode, tile_col, tile_row, pix_col, pix_row,
               pen_color, direction, wrap, fill_color,
        input  ready
    );

    modport sink (
        input  valid, mode, tile_col, tile_row, pix_col, pix_row,
               pen_color, direction, wrap, fill_color,
        output ready
    );
endinterface

// ===== hdl/cdgss_rsp_if.sv =====
interface cdgss_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       status;

    modport source (
        output valid, read_data, status,
        input  ready
    );

    modport sink (
        input  valid, read_data, status,
        output ready
    );
endinterface

// ===== hdl/cdgss_dp.sv =====
module cdgss_dp #(
    parameter int SCREEN_WIDTH  = 300,
    parameter int SCREEN_HEIGHT = 216,
    parameter int TILE_WIDTH    = 6,
    parameter int TILE_HEIGHT   = 12,
    localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cdgss_pkg::cmd_t    cmd,
    input  logic [ADDR_W-1:0]  src_addr,
    input  logic [ADDR_W-1:0]  dst_addr,
    input  logic [1:0]         mode,
    input  logic [5:0]         tile_col,
    input  logic [4:0]         tile_row,
    input  logic [2:0]         pix_col,
    input  logic [3:0]         pix_row,
    input  logic [7:0]         pen_color,
    input  logic [1:0]         direction,
    input  logic               wrap,
    input  logic [7:0]         fill_color,
    output logic [7:0]         read_data,
    output logic               status,
    output cdgss_pkg::stat_t   stat
);
    import cdgss_pkg::*;

    localparam int PIX          = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PIX_A        = $clog2(PIX);
    localparam int VS           = (TILE_HEIGHT < SCREEN_HEIGHT) ? TILE_HEIGHT : SCREEN_HEIGHT;
    localparam int BAND_DEPTH   = SCREEN_WIDTH * VS;
    localparam int BAND_A       = $clog2(BAND_DEPTH);
    localparam int TILES_ACROSS = SCREEN_WIDTH / TILE_WIDTH;
    localparam int TILES_DOWN   = SCREEN_HEIGHT / TILE_HEIGHT;
    localparam int X_W          = $clog2(64 * TILE_WIDTH + 8);
    localparam int Y_W          = $clog2(32 * TILE_HEIGHT + 16);
    localparam logic [ADDR_W-1:0] A_WIDTH = ADDR_W'(SCREEN_WIDTH);

    logic [7:0] screen_mem [PIX];
    logic [7:0] band_mem [BAND_DEPTH];

    mode_t             mode_reg;
    logic [1:0]        dir_reg;
    logic              wrap_reg;
    logic [7:0]        fill_reg;
    logic [7:0]        value_reg;
    logic              err_reg;
    logic [X_W-1:0]    x_reg;
    logic [Y_W-1:0]    y_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic              wv_reg;
    logic              wband_reg;
    logic [ADDR_W-1:0] waddr_reg;
    src_t              wsrc_reg;

    logic [7:0]        scr_rdata_reg;
    logic [7:0]        band_rdata_reg;
    logic [7:0]        rd_out_reg;
    logic              st_out_reg;

    logic              oob;
    logic              pixel_mode;
    logic [X_W-1:0]    x_next;
    logic [Y_W-1:0]    y_next;
    logic [ADDR_W-1:0] idx_next;
    logic [7:0]        move_data;

    logic              scr_we;
    logic              scr_re;
    logic [PIX_A-1:0]  scr_waddr;
    logic [PIX_A-1:0]  scr_raddr;
    logic [7:0]        scr_wdata;
    logic              band_we;
    logic              band_re;
    logic [BAND_A-1:0] band_waddr;
    logic [BAND_A-1:0] band_raddr;

    always_comb
    begin
        oob = (int'(tile_col) >= TILES_ACROSS) || (int'(tile_row) >= TILES_DOWN) ||
              (int'(pix_col) >= TILE_WIDTH) || (int'(pix_row) >= TILE_HEIGHT);
        pixel_mode = (mode_t'(mode) == MODE_WRITE) || (mode_t'(mode) == MODE_READ);
        x_next = X_W'(tile_col) * X_W'(TILE_WIDTH) + X_W'(pix_col);
        y_next = Y_W'(tile_row) * Y_W'(TILE_HEIGHT) + Y_W'(pix_row);
        idx_next = ADDR_W'(y_reg) * A_WIDTH + ADDR_W'(x_reg);
    end

    always_comb
    begin
        unique case (wsrc_reg)
            SRC_MEM:  move_data = scr_rdata_reg;
            SRC_BAND: move_data = band_rdata_reg;
            SRC_FILL: move_data = fill_reg;
            SRC_ZERO: move_data = 8'd0;
        endcase
    end

    // A move reads its source in one cycle and writes the destination in the next.
    always_comb
    begin
        if (cmd.op == OP_WRITE_PIX)
        begin
            scr_we    = 1'b1;
            scr_waddr = idx_reg[PIX_A-1:0];
            scr_wdata = value_reg;
        end
        else
        begin
            scr_we    = wv_reg && !wband_reg;
            scr_waddr = waddr_reg[PIX_A-1:0];
            scr_wdata = move_data;
        end
        if (cmd.op == OP_READ_PIX)
        begin
            scr_re    = 1'b1;
            scr_raddr = idx_reg[PIX_A-1:0];
        end
        else
        begin
            scr_re    = (cmd.op == OP_MOVE) && (cmd.src == SRC_MEM);
            scr_raddr = src_addr[PIX_A-1:0];
        end
        band_we    = wv_reg && wband_reg;
        band_waddr = waddr_reg[BAND_A-1:0];
        band_re    = (cmd.op == OP_MOVE) && (cmd.src == SRC_BAND);
        band_raddr = src_addr[BAND_A-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re)
        begin
            scr_rdata_reg <= screen_mem[scr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (band_we)
        begin
            band_mem[band_waddr] <= move_data;
        end
        if (band_re)
        begin
            band_rdata_reg <= band_mem[band_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= (cmd.op == OP_MOVE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MOVE)
        begin
            wband_reg <= cmd.dst_band;
            waddr_reg <= dst_addr;
            wsrc_reg  <= cmd.src;
        end
        if (cmd.op == OP_LOAD)
        begin
            mode_reg  <= mode_t'(mode);
            dir_reg   <= direction;
            wrap_reg  <= wrap;
            fill_reg  <= fill_color;
            value_reg <= pen_color;
            err_reg   <= pixel_mode && oob;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
        if (cmd.op == OP_INDEX)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.op == OP_RESULT)
        begin
            rd_out_reg <= (mode_reg == MODE_READ && !err_reg) ? scr_rdata_reg : 8'd0;
            st_out_reg <= err_reg;
        end
    end

    assign read_data = rd_out_reg;
    assign status    = st_out_reg;
    assign stat      = '{mode: mode_reg, dir: dir_reg, wrap: wrap_reg, err: err_reg};

    a_scr_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (scr_re && scr_we) |-> (scr_raddr != scr_waddr))
        else $error("screen read and write hit the same pixel in one cycle");

    a_band_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (band_re && band_we) |-> (band_raddr != band_waddr))
        else $error("band read and write hit the same entry in one cycle");

    a_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WRITE_PIX) |-> !err_reg)
        else $error("pixel write issued for out-of-bounds coordinates");

endmodule

// ===== hdl/cdgss_ctrl.sv =====
module cdgss_ctrl #(
    parameter int SCREEN_WIDTH  = 300,
    parameter int SCREEN_HEIGHT = 216,
    parameter int TILE_WIDTH    = 6,
    parameter int TILE_HEIGHT   = 12,
    localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cdgss_pkg::stat_t   stat,
    output cdgss_pkg::cmd_t    cmd,
    output logic [ADDR_W-1:0]  src_addr,
    output logic [ADDR_W-1:0]  dst_addr
);
    import cdgss_pkg::*;

    localparam int PIX    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int HS     = (TILE_WIDTH < SCREEN_WIDTH) ? TILE_WIDTH : SCREEN_WIDTH;
    localparam int VS     = (TILE_HEIGHT < SCREEN_HEIGHT) ? TILE_HEIGHT : SCREEN_HEIGHT;
    localparam int LINE_W = $clog2(SCREEN_HEIGHT);

    localparam logic [ADDR_W-1:0] ONE      = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] A_WIDTH  = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] A_PIX_M1 = ADDR_W'(PIX - 1);
    localparam logic [ADDR_W-1:0] H_LEN    = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] H_SH     = ADDR_W'(HS);
    localparam logic [ADDR_W-1:0] H_LMS    = ADDR_W'(SCREEN_WIDTH - HS);
    localparam logic [ADDR_W-1:0] V_LEN    = ADDR_W'(PIX);
    localparam logic [ADDR_W-1:0] V_SH     = ADDR_W'(SCREEN_WIDTH * VS);
    localparam logic [ADDR_W-1:0] V_LMS    = ADDR_W'(PIX - SCREEN_WIDTH * VS);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(SCREEN_HEIGHT - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] sh;
    logic [ADDR_W-1:0] lms;
    logic [ADDR_W-1:0] nb;
    logic              back;
    logic              last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            src_reg       <= '0;
            dst_reg       <= '0;
            cnt_reg       <= A_PIX_M1;
            base_reg      <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A scroll is done region by region: one line for a horizontal scroll, the whole
    // screen for a vertical one. Each region saves the band that leaves, shifts the
    // rest, then refills the uncovered band.
    always_comb
    begin
        len  = (stat.mode == MODE_HSCROLL) ? H_LEN : V_LEN;
        sh   = (stat.mode == MODE_HSCROLL) ? H_SH : V_SH;
        lms  = (stat.mode == MODE_HSCROLL) ? H_LMS : V_LMS;
        back = (stat.dir == DIR_BACK);
        last = (cnt_reg == '0);
        nb   = base_reg + A_WIDTH;

        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NONE, src: SRC_ZERO, dst_band: 1'b0};
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op   = OP_MOVE;
                cmd.src  = SRC_ZERO;
                dst_next = dst_reg + ONE;
                cnt_next = cnt_reg - ONE;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.mode == MODE_WRITE || stat.mode == MODE_READ)
                begin
                    if (stat.err)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_INDEX;
                        state_next = ST_PIXEL;
                    end
                end
                else if (stat.dir == DIR_FWD || stat.dir == DIR_BACK)
                begin
                    base_next  = '0;
                    line_next  = '0;
                    src_next   = back ? '0 : lms;
                    dst_next   = '0;
                    cnt_next   = sh - ONE;
                    state_next = ST_BAND;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PIXEL:
            begin
                cmd.op     = (stat.mode == MODE_WRITE) ? OP_WRITE_PIX : OP_READ_PIX;
                state_next = ST_DONE;
            end
            ST_BAND:
            begin
                cmd.op       = OP_MOVE;
                cmd.src      = SRC_MEM;
                cmd.dst_band = 1'b1;
                src_next     = src_reg + ONE;
                dst_next     = dst_reg + ONE;
                cnt_next     = cnt_reg - ONE;
                if (last)
                begin
                    // When the tile covers the whole screen there is nothing to shift.
                    if (lms != '0)
                    begin
                        src_next   = back ? base_reg + sh : base_reg + lms - ONE;
                        dst_next   = back ? base_reg : base_reg + len - ONE;
                        cnt_next   = lms - ONE;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        src_next   = '0;
                        dst_next   = back ? base_reg + lms : base_reg;
                        cnt_next   = sh - ONE;
                        state_next = ST_REFILL;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.op   = OP_MOVE;
                cmd.src  = SRC_MEM;
                src_next = back ? src_reg + ONE : src_reg - ONE;
                dst_next = back ? dst_reg + ONE : dst_reg - ONE;
                cnt_next = cnt_reg - ONE;
                if (last)
                begin
                    src_next   = '0;
                    dst_next   = back ? base_reg + lms : base_reg;
                    cnt_next   = sh - ONE;
                    state_next = ST_REFILL;
                end
            end
            ST_REFILL:
            begin
                cmd.op   = OP_MOVE;
                cmd.src  = stat.wrap ? SRC_BAND : SRC_FILL;
                src_next = src_reg + ONE;
                dst_next = dst_reg + ONE;
                cnt_next = cnt_reg - ONE;
                if (last)
                begin
                    if (stat.mode == MODE_HSCROLL && line_reg != LINE_LAST)
                    begin
                        line_next  = line_reg + LINE_W'(1);
                        base_next  = nb;
                        src_next   = back ? nb : nb + lms;
                        dst_next   = '0;
                        cnt_next   = sh - ONE;
                        state_next = ST_BAND;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign src_addr  = src_reg;
    assign dst_addr  = dst_reg;

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over one that has not been transferred");

    a_shift_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && cnt_reg == '0) |=> (state_reg == ST_REFILL))
        else $error("shift phase did not end on its last pixel");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= LINE_LAST)
        else $error("line counter ran past the last screen line");

endmodule

// ===== hdl/cdg_screen_scroll_engine.sv =====
// Channel   Direction  Payload
// req       in         mode, tile_col, tile_row, pix_col, pix_row, pen_color,
//                      direction, wrap, fill_color
// rsp       out        read_data, status
//
// After reset the screen memory is cleared one pixel a cycle, SCREEN_WIDTH*SCREEN_HEIGHT
// pixels (64800 by default), and req.ready stays low during that pass.
// One item is handled at a time. A pixel write or read passes the decode, pixel and done
// states before its result is registered; an out-of-bounds access or a scroll with an
// unused direction goes from decode straight to done. A scroll moves one pixel a cycle,
// set by the single write port of the screen memory: a horizontal one line by line, a
// vertical one over the whole screen. A stalled result waits in the output register
// while the next item is already taken; a new result waits until that one is transferred.
module cdg_screen_scroll_engine #(
    parameter int SCREEN_WIDTH  = 300,
    parameter int SCREEN_HEIGHT = 216,
    parameter int TILE_WIDTH    = 6,
    parameter int TILE_HEIGHT   = 12
) (
    input  logic  clk,
    input  logic  rst_n,
    cdgss_req_if.sink   req,
    cdgss_rsp_if.source rsp
);
    import cdgss_pkg::*;

    localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

    cmd_t              cmd;
    stat_t             stat;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;

    cdgss_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TILE_WIDTH    (TILE_WIDTH),
        .TILE_HEIGHT   (TILE_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr)
    );

    cdgss_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TILE_WIDTH    (TILE_WIDTH),
        .TILE_HEIGHT   (TILE_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .mode        (req.mode),
        .tile_col    (req.tile_col),
        .tile_row    (req.tile_row),
        .pix_col     (req.pix_col),
        .pix_row     (req.pix_row),
        .pen_color   (req.pen_color),
        .direction   (req.direction),
        .wrap        (req.wrap),
        .fill_color  (req.fill_color),
        .read_data   (rsp.read_data),
        .status      (rsp.status),
        .stat        (stat)
    );

endmodule

// ===== test/testbench.sv =====
module testbench;
    import cdgss_pkg::*;

    localparam int WIDTH = 300;
    localparam int HEIGHT = 216;
    localparam int TILE_W = 6;
    localparam int TILE_H = 12;
    localparam int TILES_X = WIDTH / TILE_W;
    localparam int TILES_Y = HEIGHT / TILE_H;
    localparam int PIXELS = WIDTH * HEIGHT;
    localparam int H_STEP = (TILE_W < WIDTH) ? TILE_W : WIDTH;
    localparam int V_STEP = (TILE_H < HEIGHT) ? TILE_H : HEIGHT;
    localparam int V_BAND = WIDTH * V_STEP;

    localparam int RANDOM_ITEMS = 75;
    // Each scroll rewrites every pixel of the screen, so the number of real scrolls is capped.
    localparam int SCROLL_LIMIT = 22;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTS = 40;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        mode_t      mode;
        logic [5:0] tile_col;
        logic [4:0] tile_row;
        logic [2:0] pix_col;
        logic [3:0] pix_row;
        logic [7:0] pen_color;
        logic [1:0] direction;
        logic       wrap;
        logic [7:0] fill_color;
    } pixel_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } pixel_rsp_t;

    typedef struct packed {
        pixel_cmd_t cmd;
        logic       typed;
        pixel_rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    cdgss_req_if req ();
    cdgss_rsp_if rsp ();

    cdg_screen_scroll_engine #(
        .SCREEN_WIDTH  (WIDTH),
        .SCREEN_HEIGHT (HEIGHT),
        .TILE_WIDTH    (TILE_W),
        .TILE_HEIGHT   (TILE_H)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [7:0] screen_copy [PIXELS];
    logic [7:0] screen_prev [PIXELS];

    plan_row_t  plan [$];
    pixel_rsp_t expected_rsp [$];

    int failures = 0;
    int results_seen = 0;
    int scrolls_done = 0;
    int idle_scrolls = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_oob = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("cdg_screen_scroll_engine test failed");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        failures++;
        if (failures <= MAX_PRINTS)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    function automatic void plan_add(mode_t m, int tc, int tr, int pc, int pr, int pv,
                                     logic [1:0] dir, int wr, int fc, bit typed,
                                     int want_data, int want_status);
        plan_row_t r;
        r.cmd.mode = m;
        r.cmd.tile_col = 6'(tc);
        r.cmd.tile_row = 5'(tr);
        r.cmd.pix_col = 3'(pc);
        r.cmd.pix_row = 4'(pr);
        r.cmd.pen_color = 8'(pv);
        r.cmd.direction = dir;
        r.cmd.wrap = 1'(wr);
        r.cmd.fill_color = 8'(fc);
        r.typed = typed;
        r.want.read_data = 8'(want_data);
        r.want.status = 1'(want_status);
        plan.push_back(r);
    endfunction

    function automatic void scroll_lines(logic [1:0] dir, logic wrap, logic [7:0] fill);
        logic [7:0] line [WIDTH];
        int x;
        int y;
        for (y = 0; y < HEIGHT; y++)
        begin
            for (x = 0; x < WIDTH; x++)
                line[x] = screen_copy[y * WIDTH + x];
            for (x = 0; x < WIDTH; x++)
            begin
                if (dir == DIR_BACK)
                    screen_copy[y * WIDTH + x] = (x < WIDTH - H_STEP) ? line[x + H_STEP] :
                        (wrap ? line[x - (WIDTH - H_STEP)] : fill);
                else
                    screen_copy[y * WIDTH + x] = (x >= H_STEP) ? line[x - H_STEP] :
                        (wrap ? line[x + WIDTH - H_STEP] : fill);
            end
        end
    endfunction

    function automatic void scroll_rows(logic [1:0] dir, logic wrap, logic [7:0] fill);
        int i;
        for (i = 0; i < PIXELS; i++)
            screen_prev[i] = screen_copy[i];
        for (i = 0; i < PIXELS; i++)
        begin
            if (dir == DIR_BACK)
                screen_copy[i] = (i < PIXELS - V_BAND) ? screen_prev[i + V_BAND] :
                    (wrap ? screen_prev[i - (PIXELS - V_BAND)] : fill);
            else
                screen_copy[i] = (i >= V_BAND) ? screen_prev[i - V_BAND] :
                    (wrap ? screen_prev[i + PIXELS - V_BAND] : fill);
        end
    endfunction

    function automatic pixel_rsp_t screen_apply(pixel_cmd_t c);
        pixel_rsp_t r;
        int spot;
        r.read_data = 8'h00;
        r.status = 1'b0;
        if (c.mode == MODE_WRITE || c.mode == MODE_READ)
        begin
            if (int'(c.tile_col) >= TILES_X || int'(c.tile_row) >= TILES_Y ||
                int'(c.pix_col) >= TILE_W || int'(c.pix_row) >= TILE_H)
                r.status = 1'b1;
            else
            begin
                spot = (int'(c.tile_row) * TILE_H + int'(c.pix_row)) * WIDTH +
                       int'(c.tile_col) * TILE_W + int'(c.pix_col);
                if (c.mode == MODE_WRITE)
                    screen_copy[spot] = c.pen_color;
                else
                    r.read_data = screen_copy[spot];
            end
        end
        else if (c.direction == DIR_FWD || c.direction == DIR_BACK)
        begin
            if (c.mode == MODE_HSCROLL)
                scroll_lines(c.direction, c.wrap, c.fill_color);
            else
                scroll_rows(c.direction, c.wrap, c.fill_color);
        end
        return r;
    endfunction

    function automatic pixel_cmd_t random_cmd(bit allow_scroll);
        pixel_cmd_t c;
        int pick;
        int spot;
        int k;
        int x;
        int y;
        c.mode = MODE_WRITE;
        c.tile_col = 6'($urandom_range(0, 63));
        c.tile_row = 5'($urandom_range(0, 31));
        c.pix_col = 3'($urandom_range(0, 7));
        c.pix_row = 4'($urandom_range(0, 15));
        c.pen_color = 8'($urandom_range(0, 255));
        c.direction = 2'($urandom_range(0, 3));
        c.wrap = 1'($urandom_range(0, 1));
        c.fill_color = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            c.mode = (pick < 40) ? MODE_WRITE : MODE_READ;
            // Most accesses land on the screen; half of those reads go to a painted pixel, if one exists.
            if ($urandom_range(0, 4) != 0)
            begin
                spot = $urandom_range(0, PIXELS - 1);
                if (c.mode == MODE_READ && $urandom_range(0, 1) == 1)
                begin
                    for (k = 0; k < PIXELS; k++)
                    begin
                        if (screen_copy[(spot + k) % PIXELS] != 8'h00)
                        begin
                            spot = (spot + k) % PIXELS;
                            break;
                        end
                    end
                end
                x = spot % WIDTH;
                y = spot / WIDTH;
                c.tile_col = 6'(x / TILE_W);
                c.pix_col = 3'(x % TILE_W);
                c.tile_row = 5'(y / TILE_H);
                c.pix_row = 4'(y % TILE_H);
            end
        end
        else
        begin
            c.mode = ($urandom_range(0, 1) == 1) ? MODE_HSCROLL : MODE_VSCROLL;
            if (!allow_scroll || $urandom_range(0, 9) < 3)
                c.direction = ($urandom_range(0, 1) == 1) ? DIR_NONE : DIR_SPARE;
            else
                c.direction = ($urandom_range(0, 1) == 1) ? DIR_FWD : DIR_BACK;
        end
        return c;
    endfunction

    task automatic drive_fields(pixel_cmd_t c);
        req.mode <= c.mode;
        req.tile_col <= c.tile_col;
        req.tile_row <= c.tile_row;
        req.pix_col <= c.pix_col;
        req.pix_row <= c.pix_row;
        req.pen_color <= c.pen_color;
        req.direction <= c.direction;
        req.wrap <= c.wrap;
        req.fill_color <= c.fill_color;
    endtask

    // Result side: compare every transfer with the oldest outstanding expectation.
    always @(posedge clk)
    begin : check_results
        pixel_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("unexpected result, read_data", int'(rsp.read_data), 0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", int'(rsp.read_data),
                                    int'(want.read_data));
                if (rsp.status !== want.status)
                    report_mismatch("status", int'(rsp.status), int'(want.status));
            end
            results_seen++;
        end
    end

    // The receiver stalls in changing styles. Early on it holds off for a long stretch
    // so that the output register fills and the request side backs up.
    initial
    begin : result_sink
        int tick;
        int style;
        bit held;
        tick = 0;
        style = 0;
        held = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (!held && results_seen >= 2)
            begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (tick % 50 == 0)
                    style = $urandom_range(0, 3);
                case (style)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp.ready <= tick[2];
                endcase
            end
        end
    end

    initial
    begin : stimulus
        pixel_cmd_t cmd;
        pixel_rsp_t pred;
        pixel_rsp_t want;
        int n;
        int i;
        int gap;
        int burst;

        rst_n = 1'b0;
        req.valid <= 1'b0;
        drive_fields('0);
        for (i = 0; i < PIXELS; i++)
            screen_copy[i] = 8'h00;

        //       mode          tc  tr  pc  pr  value  dir        wr fill   check      data   st
        plan_add(MODE_READ,     0,  0,  0,  0, 8'h00, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 0);
        plan_add(MODE_READ,    50,  0,  0,  0, 8'h00, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 1);
        plan_add(MODE_WRITE,    0, 18,  0,  0, 8'h11, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 1);
        plan_add(MODE_WRITE,   63, 31,  7, 15, 8'hFF, DIR_SPARE, 1, 8'hFF, TYPED,     8'h00, 1);
        plan_add(MODE_READ,     0,  0,  6,  0, 8'h00, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 1);
        plan_add(MODE_WRITE,    0,  0,  0, 12, 8'h22, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 1);
        plan_add(MODE_WRITE,    0,  0,  0,  0, 8'hFF, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 0);
        plan_add(MODE_WRITE,   49, 17,  5, 11, 8'h80, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 0);
        plan_add(MODE_WRITE,   25,  9,  3,  6, 8'h55, DIR_NONE,  0, 8'h00, TYPED,     8'h00, 0);
        plan_add(MODE_READ,     0,  0,  0,  0, 8'h00, DIR_NONE,  0, 8'h00, TYPED,     8'hFF, 0);
        plan_add(MODE_READ,    49, 17,  5, 11, 8'h00, DIR_NONE,  0, 8'h00, TYPED,     8'h80, 0);
        plan_add(MODE_HSCROLL,  0,  0,  0,  0, 8'h00, DIR_BACK,  1, 8'h00, TYPED,     8'h00, 0);
        plan_add(MODE_READ,    49,  0,  0,  0, 8'h00, DIR_NONE,  0, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_HSCROLL,  0,  0,  0,  0, 8'h00, DIR_FWD,   0, 8'hA5, PREDICTED, 8'h00, 0);
        plan_add(MODE_VSCROLL,  0,  0,  0,  0, 8'h00, DIR_FWD,   1, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_READ,     0,  1,  0,  0, 8'h00, DIR_NONE,  0, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_VSCROLL,  0,  0,  0,  0, 8'h00, DIR_BACK,  0, 8'h3C, PREDICTED, 8'h00, 0);
        plan_add(MODE_READ,    49, 17,  5, 11, 8'h00, DIR_NONE,  0, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_HSCROLL,  0,  0,  0,  0, 8'h00, DIR_NONE,  1, 8'hFF, TYPED,     8'h00, 0);
        plan_add(MODE_VSCROLL,  0,  0,  0,  0, 8'h00, DIR_SPARE, 0, 8'h77, TYPED,     8'h00, 0);
        plan_add(MODE_HSCROLL,  0,  0,  0,  0, 8'h00, DIR_BACK,  0, 8'hFF, PREDICTED, 8'h00, 0);
        plan_add(MODE_HSCROLL,  0,  0,  0,  0, 8'h00, DIR_FWD,   1, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_VSCROLL,  0,  0,  0,  0, 8'h00, DIR_BACK,  1, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_VSCROLL,  0,  0,  0,  0, 8'h00, DIR_FWD,   0, 8'h00, PREDICTED, 8'h00, 0);
        plan_add(MODE_READ,    25,  9,  3,  6, 8'h00, DIR_NONE,  0, 8'h00, PREDICTED, 8'h00, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        burst = 0;
        for (n = 0; n < plan.size() + RANDOM_ITEMS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap > 0)
                begin
                    req.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst--;

            if (n < plan.size())
                cmd = plan[n].cmd;
            else
                cmd = random_cmd(scrolls_done < SCROLL_LIMIT);
            req.valid <= 1'b1;
            drive_fields(cmd);
            do
                @(posedge clk);
            while (!req.ready);

            pred = screen_apply(cmd);
            want = pred;
            if (n < plan.size() && plan[n].typed)
                want = plan[n].want;
            expected_rsp.push_back(want);

            if (cmd.mode == MODE_WRITE || cmd.mode == MODE_READ)
            begin
                if (pred.status)
                    n_oob++;
                else if (cmd.mode == MODE_WRITE)
                    n_writes++;
                else
                    n_reads++;
            end
            else if (cmd.direction == DIR_FWD || cmd.direction == DIR_BACK)
                scrolls_done++;
            else
                idle_scrolls++;
        end
        req.valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pixel writes, %0d in-bounds reads, %0d out-of-bounds accesses,",
                 n_writes, n_reads, n_oob);
        $display("%0d screen scrolls, %0d scrolls with an unused direction; %0d results, %0d errors.",
                 scrolls_done, idle_scrolls, results_seen, failures);
        if (failures == 0)
            $display("cdg_screen_scroll_engine test passed");
        else
            $display("cdg_screen_scroll_engine test failed");
        $finish;
    end

endmodule
